// ----- hw/rtl/msgadm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgadm_pkg: shared types and constants of the message admission limiter
// Field widths, register indexes and reset values, verdict codes and the sequencer states.
// ----------------------------------------------------------------------------
package msgadm_pkg;

  // Fixed field widths
  localparam int ID_W      = 6;
  localparam int LEN_W     = 12;
  localparam int CFG_W     = 32;
  localparam int MAXMSG_W  = 4;
  localparam int COUNT_W   = 4;
  localparam int VERDICT_W = 2;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]    WINDOW_RESET = 32'd10000;
  localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 4'd5;
  localparam logic [LEN_W-1:0]    MAXLEN_RESET = 12'd256;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ADMIT   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_EMPTY   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOOLONG = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_LIMITED = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_META,
    S_SCAN,
    S_APPEND
  } state_t;

endpackage

// ----- hw/rtl/message_admission_rate_limiter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_admission_rate_limiter_unit: sliding-window log rate limiter
// Per-client ring of admission stamps held in a synchronous memory, with a
// second memory for each client's ring head and fill count.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------
//  request   | in        | start, busy              | client_id, message_length,
//            |           |                          | now_ticks
//  result    | out       | result_valid (strobe)    | allowed, verdict,
//            |           |                          | count_in_window
//  config    | in        | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
//  Empty or too-long requests: result strobe in the cycle after the accept.
//  Other requests: the client number is folded into range, the head/count
//  word is read, then the stamp log is scanned, one stamp memory read per
//  cycle, and the new stamp is appended if the limit allows it.
//  After reset a clearing pass zeroes every entry of the head/count
//  memory; busy stays high meanwhile. Config writes are always taken.
//  Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module message_admission_rate_limiter_unit
  import msgadm_pkg::*;
#(
  parameter int CLIENTS   = 64,
  parameter int LOG_DEPTH = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic [ID_W-1:0]      client_id,
  input  logic [LEN_W-1:0]     message_length,
  input  logic [TIME_BITS-1:0] now_ticks,
  // result
  output logic                 result_valid,
  output logic                 allowed,
  output logic [VERDICT_W-1:0] verdict,
  output logic [COUNT_W-1:0]   count_in_window,
  // config
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW     = $clog2(CLIENTS);
  localparam int IDX_W  = (CW + 1 > ID_W) ? CW + 1 : ID_W;
  localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
  localparam int LIM_W  = (CNT_W > MAXMSG_W) ? CNT_W : MAXMSG_W;
  localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int ADDR_W = CW + SLOT_W;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } meta_t;

  // ring position wrap: the sum is always below twice the depth
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s;
    if (s >= SUM_W'(LOG_DEPTH)) begin
      t = s - SUM_W'(LOG_DEPTH);
    end
    return t[SLOT_W-1:0];
  endfunction

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0]    window_ticks;
  logic [MAXMSG_W-1:0] max_messages;
  logic [LEN_W-1:0]    max_length;

  // job registers
  logic [IDX_W-1:0]     cid;
  logic [TIME_BITS-1:0] req_now;
  logic [SLOT_W-1:0]    head;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     scan_i;
  logic [CNT_W-1:0]     keep_n;
  logic                 rd_pend;
  logic [CW-1:0]        clr_idx;

  // memories
  logic [TIME_BITS-1:0] stamp_mem [CLIENTS << SLOT_W];
  logic [TIME_BITS-1:0] stamp_q;
  meta_t                meta_mem  [CLIENTS];
  meta_t                meta_q;

  // memory ports
  logic                 stamp_re, stamp_we;
  logic [ADDR_W-1:0]    stamp_raddr, stamp_waddr;
  logic [TIME_BITS-1:0] stamp_wdata;
  logic                 meta_re, meta_we;
  logic [CW-1:0]        meta_raddr, meta_waddr;
  meta_t                meta_wdata;

  // datapath helpers
  logic [CW-1:0]        client;
  logic [SLOT_W-1:0]    rd_slot, wr_slot;
  logic [TIME_BITS-1:0] age;
  logic                 keep;
  logic [LIM_W-1:0]     limit;
  logic                 full;
  logic                 accept;
  logic                 reject_now;

  assign client     = cid[CW-1:0];
  assign rd_slot    = slot_wrap(SUM_W'(head) + SUM_W'(scan_i));
  assign wr_slot    = slot_wrap(SUM_W'(head) + SUM_W'(keep_n));
  assign age        = req_now - stamp_q;
  assign keep       = CMP_W'(age) <= CMP_W'(window_ticks);
  assign limit      = (LIM_W'(max_messages) > LIM_W'(LOG_DEPTH)) ?
                      LIM_W'(LOG_DEPTH) : LIM_W'(max_messages);
  assign full       = LIM_W'(keep_n) >= limit;
  assign accept     = start && !busy;
  assign reject_now = (message_length == '0) || (message_length > max_length);
  assign cfg_ready  = 1'b1;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      max_messages <= MAXMSG_RESET;
      max_length   <= MAXLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_TICKS: window_ticks <= cfg_data;
        CFG_MAX_MESSAGES: max_messages <= cfg_data[MAXMSG_W-1:0];
        CFG_MAX_LENGTH:   max_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    stamp_re    = 1'b0;
    stamp_raddr = {client, rd_slot};
    stamp_we    = 1'b0;
    stamp_waddr = {client, wr_slot};
    stamp_wdata = stamp_q;
    meta_re     = 1'b0;
    meta_raddr  = client;
    meta_we     = 1'b0;
    meta_waddr  = client;
    meta_wdata  = '{head: head, count: keep_n};
    unique case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
        if (clr_idx == CW'(CLIENTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start && !reject_now) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        // fold the client number into range, one subtract a cycle
        if (cid < IDX_W'(CLIENTS)) begin
          meta_re    = 1'b1;
          state_next = S_META;
        end
      end
      S_META: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        stamp_re = (scan_i != cnt);
        // kept stamps are packed down from the head
        if (rd_pend && keep) begin
          stamp_we = 1'b1;
        end
        if ((scan_i == cnt) && !rd_pend) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        meta_we = 1'b1;
        if (!full) begin
          stamp_we    = 1'b1;
          stamp_wdata = req_now;
          meta_wdata  = '{head: head, count: keep_n + CNT_W'(1)};
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    if (stamp_re) begin
      stamp_q <= stamp_mem[stamp_raddr];
    end
  end

  // head / count memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q <= meta_mem[meta_raddr];
    end
  end

  // job datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= stamp_re;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + CW'(1);
      end
    end
    if (accept) begin
      cid     <= IDX_W'(client_id);
      req_now <= now_ticks;
    end
    if ((state == S_MAP) && (cid >= IDX_W'(CLIENTS))) begin
      cid <= cid - IDX_W'(CLIENTS);
    end
    if (state == S_META) begin
      head   <= meta_q.head;
      cnt    <= (meta_q.count > CNT_W'(LOG_DEPTH)) ? CNT_W'(LOG_DEPTH) : meta_q.count;
      scan_i <= '0;
      keep_n <= '0;
    end
    if (state == S_SCAN) begin
      if (stamp_re) begin
        scan_i <= scan_i + CNT_W'(1);
      end
      if (rd_pend && keep) begin
        keep_n <= keep_n + CNT_W'(1);
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (accept && reject_now) || (state == S_APPEND);
    end
    if (accept && reject_now) begin
      allowed         <= 1'b0;
      verdict         <= (message_length == '0) ? VERDICT_EMPTY : VERDICT_TOOLONG;
      count_in_window <= '0;
    end else if (state == S_APPEND) begin
      allowed         <= !full;
      verdict         <= full ? VERDICT_LIMITED : VERDICT_ADMIT;
      count_in_window <= full ? COUNT_W'(keep_n) : COUNT_W'(keep_n + CNT_W'(1));
    end
  end

  // checks
  a_allowed_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (allowed == (verdict == VERDICT_ADMIT)))
    else $error("allowed disagrees with verdict");

  a_keep_behind_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (keep_n <= scan_i))
    else $error("write-back position overtook read position");

  a_append_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |=> result_valid)
    else $error("no result after append");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN))
    else $error("stamp read returned outside scan");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_i <= cnt))
    else $error("scan ran past the log count");

endmodule

// ----- tb/tb_message_admission_rate_limiter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_admission_rate_limiter_unit: self-checking bench for the limiter
// Drives request words with random gaps and predicts each verdict from a
// local sliding-window log per client. Every strobed result is checked
// against the oldest prediction. A short directed pass comes first, then
// random traffic over several register settings.
// ----------------------------------------------------------------------------
module tb_message_admission_rate_limiter_unit;
  import msgadm_pkg::*;

  localparam int NUM_CLIENTS    = 64;
  localparam int RING_DEPTH     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 80;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                 allowed;
    logic [VERDICT_W-1:0] verdict;
    logic [COUNT_W-1:0]   count;
  } admit_word_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [ID_W-1:0]      client_id;
  logic [LEN_W-1:0]     message_length;
  logic [31:0]          now_ticks;
  logic                 result_valid;
  logic                 allowed;
  logic [VERDICT_W-1:0] verdict;
  logic [COUNT_W-1:0]   count_in_window;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  message_admission_rate_limiter_unit uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .client_id       (client_id),
    .message_length  (message_length),
    .now_ticks       (now_ticks),
    .result_valid    (result_valid),
    .allowed         (allowed),
    .verdict         (verdict),
    .count_in_window (count_in_window),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Predictor state: per-client stamp log, packed from slot 0
  logic [31:0]        stamp_ring [NUM_CLIENTS][RING_DEPTH];
  int                 ring_fill  [NUM_CLIENTS];
  logic [CFG_W-1:0]   win_ticks_q;
  logic [MAXMSG_W-1:0] msg_cap_q;
  logic [LEN_W-1:0]   len_cap_q;

  admit_word_t        expected_verdicts [$];
  admit_word_t        oldest_verdict;
  int                 fail_count;
  int                 quiet_cycles;
  bit                 idling_on;
  logic [31:0]        time_cursor;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Verdict for one request; updates the local log as the block should
  function automatic admit_word_t judge_request(input logic [ID_W-1:0] id,
                                                input logic [LEN_W-1:0] len,
                                                input logic [31:0] now);
    admit_word_t w;
    logic [31:0] kept [RING_DEPTH];
    int          n;
    int          cap;
    w   = '0;
    n   = 0;
    cap = (msg_cap_q > RING_DEPTH) ? RING_DEPTH : int'(msg_cap_q);
    if (len == '0) begin
      w.verdict = VERDICT_EMPTY;
      return w;
    end
    if (len > len_cap_q) begin
      w.verdict = VERDICT_TOOLONG;
      return w;
    end
    // drop stale stamps wherever they sit, keep the rest in order
    for (int i = 0; i < ring_fill[id]; i++) begin
      if (32'(now - stamp_ring[id][i]) <= win_ticks_q) begin
        kept[n] = stamp_ring[id][i];
        n++;
      end
    end
    for (int i = 0; i < n; i++) stamp_ring[id][i] = kept[i];
    ring_fill[id] = n;
    if (n >= cap) begin
      w.verdict = VERDICT_LIMITED;
      w.count   = COUNT_W'(n);
      return w;
    end
    stamp_ring[id][n] = now;
    ring_fill[id]     = n + 1;
    w.allowed = 1'b1;
    w.verdict = VERDICT_ADMIT;
    w.count   = COUNT_W'(n + 1);
    return w;
  endfunction

  // Append one prediction at the tail of the expected queue
  task automatic add_expected(input admit_word_t w);
    expected_verdicts = {expected_verdicts, w};
  endtask

  // Result checker: each strobed word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected: allowed %0d verdict %0d count %0d",
                 $time, allowed, verdict, count_in_window);
        fail_count++;
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (allowed !== oldest_verdict.allowed) begin
          $display("%0t: allowed mismatch, expected %0d actual %0d",
                   $time, oldest_verdict.allowed, allowed);
          fail_count++;
        end
        if (verdict !== oldest_verdict.verdict) begin
          $display("%0t: verdict mismatch, expected %0d actual %0d",
                   $time, oldest_verdict.verdict, verdict);
          fail_count++;
        end
        if (count_in_window !== oldest_verdict.count) begin
          $display("%0t: count_in_window mismatch, expected %0d actual %0d",
                   $time, oldest_verdict.count, count_in_window);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, expected_verdicts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one request word; start stays high afterwards until the next
  // call or a settle changes it
  task automatic send_request(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [31:0] now);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    client_id      <= id;
    message_length <= len;
    now_ticks      <= now;
    do @(posedge clk); while (busy);
    add_expected(judge_request(id, len, now));
  endtask

  // Stop sending and wait until every result is in and the block is idle
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (expected_verdicts.size() != 0 || busy) @(negedge clk);
  endtask

  // Register write, only ever issued with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_TICKS: win_ticks_q = data;
      CFG_MAX_MESSAGES: msg_cap_q   = data[MAXMSG_W-1:0];
      CFG_MAX_LENGTH:   len_cap_q   = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Empty, shortest, longest-allowed and too-long lengths at reset settings
  task automatic test_length_checks();
    send_request(6'd0,  12'd0,   32'd0);
    send_request(6'd63, 12'hFFF, 32'hFFFF_FFFF);
    send_request(6'd0,  12'd256, 32'd0);
    send_request(6'd63, 12'd257, 32'd5);
    send_request(6'd1,  12'd1,   32'hFFFF_FFFF);
  endtask

  // Fill one client to the limit, then probe the window boundary
  task automatic test_burst_limit();
    for (int i = 0; i < 6; i++) send_request(6'd9, 12'd40, 32'd1000);
    send_request(6'd9, 12'd40, 32'd11000);  // age equals window: still held
    send_request(6'd9, 12'd40, 32'd11001);  // all stale: admitted afresh
  endtask

  // Zero window keeps same-tick stamps only; full window keeps everything
  task automatic test_window_edges();
    write_reg(CFG_WINDOW_TICKS, 32'd0);
    send_request(6'd20, 12'd3, 32'd500);
    send_request(6'd20, 12'd3, 32'd500);
    send_request(6'd20, 12'd3, 32'd501);
    write_reg(CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
    send_request(6'd21, 12'd3, 32'd7);
    send_request(6'd21, 12'd3, 32'd3);
  endtask

  // Time running backwards drops the newest stamp from the end of the log
  task automatic test_stamp_order();
    write_reg(CFG_WINDOW_TICKS, 32'd100);
    send_request(6'd30, 12'd9, 32'd1000);
    send_request(6'd30, 12'd9, 32'd1050);
    send_request(6'd30, 12'd9, 32'd1020);
    send_request(6'd30, 12'd9, 32'd1110);
  endtask

  // Zero length cap, zero message cap and a write to the spare index
  task automatic test_register_corners();
    write_reg(CFG_MAX_LENGTH, 32'd0);
    send_request(6'd2, 12'd1, 32'd77);
    write_reg(CFG_MAX_LENGTH, 32'd256);
    write_reg(CFG_MAX_MESSAGES, 32'd0);
    send_request(6'd3, 12'd5, 32'd77);
    write_reg(CFG_MAX_MESSAGES, 32'd5);
    write_reg(CFG_SPARE, $urandom);
    send_request(6'd3, 12'd256, 32'd78);
  endtask

  // Random traffic: a few busy clients per setting, with some noise
  task automatic test_random_traffic();
    logic [CFG_W-1:0]  w;
    logic [31:0]       m;
    logic [31:0]       l;
    logic [31:0]       step;
    logic [ID_W-1:0]   hot [4];
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [31:0]       now;
    int                roll;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      m = $urandom;
      l = $urandom;
      case (p)
        0: begin
          w = 32'hFFFF_FFFF; m[3:0] = 4'd8;  l[11:0] = 12'hFFF;
        end
        1: begin
          w = 32'd0;         m[3:0] = 4'd1;  l[11:0] = 12'd1;
        end
        2: begin
          w = $urandom_range(20, 200); m[3:0] = 4'd15;
          l[11:0] = 12'($urandom_range(2, 4094));
        end
        default: begin
          w = (p % 2) ? 32'($urandom_range(0, 5000)) : 32'($urandom);
          m[3:0]  = 4'($urandom_range(1, 15));
          l[11:0] = 12'($urandom_range(1, 4095));
        end
      endcase
      write_reg(CFG_WINDOW_TICKS, w);
      write_reg(CFG_MAX_MESSAGES, m);
      write_reg(CFG_MAX_LENGTH, l);
      foreach (hot[i]) hot[i] = 6'($urandom_range(0, NUM_CLIENTS - 1));
      // odd phases start close to the wrap of the time base
      time_cursor = (p % 2) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 2000)) : 32'($urandom);
      idling_on = (p != RANDOM_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) settle_block();
        roll = $urandom_range(0, 99);
        id   = hot[$urandom_range(0, 3)];
        len  = (len_cap_q == '0) ? 12'($urandom_range(1, 4095))
                                 : 12'($urandom_range(1, len_cap_q));
        if (roll < 85) begin
          // well-formed: time moves forward by zero, a small, a window-related or a random step
          case ($urandom_range(0, 5))
            0: step = 32'd0;
            1: step = 32'($urandom_range(1, 8));
            2: step = win_ticks_q >> 3;
            3: step = win_ticks_q;
            4: step = win_ticks_q + 32'd1;
            default: step = $urandom;
          endcase
          time_cursor = time_cursor + step;
          now = time_cursor;
        end else begin
          now = $urandom;
          case ($urandom_range(0, 3))
            0: len = '0;
            1: len = (len_cap_q == 12'hFFF) ? 12'd0
                                           : 12'($urandom_range(len_cap_q + 1, 4095));
            2: now = time_cursor - 32'($urandom_range(1, 1000));
            default: begin
              id  = 6'($urandom);
              len = 12'($urandom);
            end
          endcase
        end
        send_request(id, len, now);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    client_id      = '0;
    message_length = '0;
    now_ticks      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_WINDOW_TICKS;
    cfg_data       = '0;
    fail_count     = 0;
    quiet_cycles   = 0;
    idling_on      = 1'b1;
    time_cursor    = '0;
    win_ticks_q    = WINDOW_RESET;
    msg_cap_q      = MAXMSG_RESET;
    len_cap_q      = MAXLEN_RESET;
    foreach (ring_fill[i]) ring_fill[i] = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_length_checks();
    test_burst_limit();
    test_window_edges();
    test_stamp_order();
    test_register_corners();
    test_random_traffic();

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/msgadm_pkg.sv
hw/rtl/message_admission_rate_limiter_unit.sv
tb/tb_message_admission_rate_limiter_unit.sv
